// ===== rtl/sclm_pkg.sv =====
// shared constants, types and command word tables for the command line matcher
package sclm_pkg;

  localparam int LINE_CAPACITY_DEF = 32;
  localparam int WORD_COUNT = 4;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_ON = 3'd1;
  localparam logic [2:0] CMD_OFF = 3'd2;
  localparam logic [2:0] CMD_TOGGLE = 3'd3;
  localparam logic [2:0] CMD_HELP = 3'd4;
  localparam logic [2:0] CMD_UNKNOWN = 3'd5;

  // result of one word as seen by the line tracker
  typedef struct packed {
    logic       done;
    logic [2:0] cmd;
    logic       over;
  } line_res_t;

  // length of each command word
  function automatic logic [3:0] word_len(input logic [1:0] k);
    logic [3:0] len;
    unique case (k)
      2'd0: len = 4'd6;
      2'd1: len = 4'd7;
      2'd2: len = 4'd10;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

  // character at position idx of command word k, zero past the end
  function automatic logic [7:0] word_char(input logic [1:0] k, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'd0;
    unique case (k)
      2'd0: begin
        unique case (idx)
          4'd0: c = "l";
          4'd1: c = "e";
          4'd2: c = "d";
          4'd3: c = " ";
          4'd4: c = "o";
          4'd5: c = "n";
          default: c = 8'd0;
        endcase
      end
      2'd1: begin
        unique case (idx)
          4'd0: c = "l";
          4'd1: c = "e";
          4'd2: c = "d";
          4'd3: c = " ";
          4'd4: c = "o";
          4'd5: c = "f";
          4'd6: c = "f";
          default: c = 8'd0;
        endcase
      end
      2'd2: begin
        unique case (idx)
          4'd0: c = "l";
          4'd1: c = "e";
          4'd2: c = "d";
          4'd3: c = " ";
          4'd4: c = "t";
          4'd5: c = "o";
          4'd6: c = "g";
          4'd7: c = "g";
          4'd8: c = "l";
          4'd9: c = "e";
          default: c = 8'd0;
        endcase
      end
      default: begin
        unique case (idx)
          4'd0: c = "h";
          4'd1: c = "e";
          4'd2: c = "l";
          4'd3: c = "p";
          default: c = 8'd0;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sclm_if.sv =====
// valid/ready channel interfaces for received and echoed words
interface sclm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source(output valid, output rx_char, input ready);
  modport sink(input valid, input rx_char, output ready);
endinterface

interface sclm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_char;
  logic       line_done;
  logic [2:0] command;
  logic       too_long;
  logic       led_level;

  modport source(output valid, output echo_char, output line_done, output command,
                 output too_long, output led_level, input ready);
  modport sink(input valid, input echo_char, input line_done, input command,
               input too_long, input led_level, output ready);
endinterface

// ===== rtl/sclm_line.sv =====
// line tracker: length count, zero byte handling and incremental prefix match flags
module sclm_line #(
  parameter int LINE_CAPACITY = sclm_pkg::LINE_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            ch,
  output sclm_pkg::line_res_t   res
);
  import sclm_pkg::*;

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_CAPACITY - 1);

  logic [CW-1:0]         char_count, char_count_next;
  logic [CW-1:0]         text_length, text_length_next;
  logic                  text_ended, text_ended_next;
  logic [WORD_COUNT-1:0] match_flags, match_flags_next;

  logic is_end;
  logic [2:0] found;

  assign is_end = (ch == CH_CR) || (ch == CH_LF);

  // lowest numbered full match wins
  always_comb begin
    found = CMD_UNKNOWN;
    for (int k = WORD_COUNT - 1; k >= 0; k--) begin
      if (match_flags[k] && (text_length == CW'(word_len(2'(k))))) begin
        found = 3'(k + 1);
      end
    end
  end

  always_comb begin
    char_count_next  = char_count;
    text_length_next = text_length;
    text_ended_next  = text_ended;
    match_flags_next = match_flags;
    res.done = is_end;
    res.cmd  = CMD_NONE;
    res.over = 1'b0;
    if (is_end) begin
      if (char_count != '0) begin
        res.cmd          = found;
        char_count_next  = '0;
        text_length_next = '0;
        text_ended_next  = 1'b0;
        match_flags_next = '1;
      end
    end else if (char_count < COUNT_MAX) begin
      char_count_next = char_count + 1'b1;
      if (!text_ended) begin
        if (ch == CH_NUL) begin
          text_ended_next = 1'b1;
        end else begin
          for (int k = 0; k < WORD_COUNT; k++) begin
            if ((text_length >= CW'(word_len(2'(k)))) ||
                (word_char(2'(k), text_length[3:0]) != ch)) begin
              match_flags_next[k] = 1'b0;
            end
          end
          text_length_next = text_length + 1'b1;
        end
      end
    end else begin
      res.over         = 1'b1;
      char_count_next  = '0;
      text_length_next = '0;
      text_ended_next  = 1'b0;
      match_flags_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= '0;
      text_length <= '0;
      text_ended  <= 1'b0;
      match_flags <= '1;
    end else if (take) begin
      char_count  <= char_count_next;
      text_length <= text_length_next;
      text_ended  <= text_ended_next;
      match_flags <= match_flags_next;
    end
  end

  a_len_le_count: assert property (@(posedge clk) disable iff (rst)
    text_length <= char_count)
    else $error("text length exceeds stored count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= COUNT_MAX)
    else $error("line count beyond capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && res.cmd != CMD_NONE |=> char_count == '0 && match_flags == '1)
    else $error("line state not cleared after line end");

endmodule

// ===== rtl/serial_command_line_matcher_unit.sv =====
// top level: serial command line matcher with echo, LED control and result register
//
// One received word is accepted per cycle unless tx stalls, and it produces exactly one echoed
// word in the next cycle: the line tracker updates its count and prefix flags in a single pass,
// and the result sits in one output register. Input is taken whenever that register is empty
// or is being emptied in the same cycle, so with no tx stalls the sustained rate is one word per
// clock with no bubbles. A CR or LF ends the line; a non-empty line reports "led on", "led off",
// "led toggle", "help" or unknown, and the LED level follows the command. A line that
// would exceed LINE_CAPACITY-1 characters drops the word, clears and flags too_long.
module serial_command_line_matcher_unit #(
  parameter int LINE_CAPACITY = sclm_pkg::LINE_CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  sclm_in_if.sink    rx,
  sclm_out_if.source tx
);
  import sclm_pkg::*;

  line_res_t  res;
  logic       acc;
  logic       led, led_next;
  logic       ovalid;
  logic [7:0] o_char;
  logic       o_done;
  logic [2:0] o_cmd;
  logic       o_over;
  logic       o_led;

  assign rx.ready = !ovalid || tx.ready;
  assign acc      = rx.valid && rx.ready;

  sclm_line #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk (clk),
    .rst (rst),
    .take(acc),
    .ch  (rx.rx_char),
    .res (res)
  );

  always_comb begin
    led_next = led;
    if (res.cmd == CMD_ON) begin
      led_next = 1'b1;
    end else if (res.cmd == CMD_OFF) begin
      led_next = 1'b0;
    end else if (res.cmd == CMD_TOGGLE) begin
      led_next = !led;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (acc) begin
        led    <= led_next;
        ovalid <= 1'b1;
      end else if (tx.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      o_char <= rx.rx_char;
      o_done <= res.done;
      o_cmd  <= res.cmd;
      o_over <= res.over;
      o_led  <= led_next;
    end
  end

  assign tx.valid     = ovalid;
  assign tx.echo_char = o_char;
  assign tx.line_done = o_done;
  assign tx.command   = o_cmd;
  assign tx.too_long  = o_over;
  assign tx.led_level = o_led;

  a_cmd_needs_end: assert property (@(posedge clk) disable iff (rst)
    ovalid && o_cmd != CMD_NONE |-> o_done)
    else $error("command reported without line end");

  a_over_excl: assert property (@(posedge clk) disable iff (rst)
    ovalid && o_over |-> !o_done && o_cmd == CMD_NONE)
    else $error("overflow combined with line end");

  a_led_only_cmd: assert property (@(posedge clk) disable iff (rst)
    acc && !res.done |=> led == $past(led))
    else $error("led changed without a line end");

  a_led_shown: assert property (@(posedge clk) disable iff (rst)
    acc |=> o_led == led)
    else $error("reported led level differs from kept level");

endmodule
